>>> src/rc4iv_pkg.sv
`default_nettype none
// ============================================================================
// rc4iv_pkg
// Shared types and constants for the RC4 keystream block with IV mixing.
// ============================================================================
package rc4iv_pkg;

    // S-box geometry (fixed by the cipher)
    localparam int unsigned SBOX_DEPTH = 256;
    localparam int unsigned SBOX_AW    = 8;

    // Configuration port
    localparam int unsigned CFG_DATA_W = 9;
    localparam logic        CFG_KEY_LEN = 1'b0;
    localparam logic        CFG_IV_LEN  = 1'b1;

    // Transaction opcodes
    typedef enum logic [1:0] {
        OP_KEY_WR = 2'd0,
        OP_IV_WR  = 2'd1,
        OP_SCHED  = 2'd2,
        OP_CRYPT  = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_RD,   // schedule: read S[i], key, IV
        ST_KS_J,    // schedule: new j, read S[j]
        ST_KS_WI,   // schedule: S[i] <= S[j]
        ST_KS_WJ,   // schedule: S[j] <= old S[i]
        ST_CR_RI,   // crypt: read S[i]
        ST_CR_J,    // crypt: new j, read S[j]
        ST_CR_WI,   // crypt: S[i] <= S[j]
        ST_CR_WJ,   // crypt: S[j] <= old S[i], read S[S[i]+S[j]]
        ST_CR_OUT   // crypt: load output register
    } t_state;

    // Request bundle from sequencer to S-box store
    typedef struct packed {
        logic [SBOX_AW-1:0] rd_addr;
        logic               wr_en;
        logic [SBOX_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic               clear;
    } t_sbox_req;

endpackage
`default_nettype wire

>>> src/rc4iv_if.sv
`default_nettype none
// ============================================================================
// rc4iv_in_if / rc4iv_out_if
// Valid/ready channels for command transactions and result bytes.
// ============================================================================
interface rc4iv_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] byte_index;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output byte_index, output data_byte,
                    input ready);
    modport sink   (input valid, input opcode, input byte_index, input data_byte,
                    output ready);
endinterface

interface rc4iv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

>>> src/rc4_stream_cipher_with_iv.sv
`default_nettype none
// ============================================================================
// rc4_stream_cipher_with_iv
// RC4 keystream engine with key and IV stores and a memory-based S-box.
// ============================================================================
// Usage:
//   i_in carries command transactions (opcode, byte_index, data_byte); o_out
//   carries one result byte per crypt command. i_cfg_* writes key_length
//   (index 0) and iv_length (index 1); the user must do so only while the
//   block is idle, as the block itself does not enforce it.
// Sequence:
//   A crypt command steps through read S[i], new j with read S[j], the
//   write of S[i], the write of S[j] with the output read, and the output
//   load on the single S-box RAM port pair; the next command is accepted
//   only once it is back in idle.
//   The key schedule runs each of the 256 S-box entries through read S[i],
//   read S[j] and two swap writes.
// Reset:
//   S-box reads as the identity right after reset (no clearing pass); i, j,
//   and both lengths are zero. Key and IV stores are undefined until written.
// Stall:
//   A finished result waits in the output register; the next command is
//   accepted meanwhile, and a crypt command waits only if its own result
//   would overwrite one not yet taken.
// ============================================================================
module rc4_stream_cipher_with_iv #(
    parameter int unsigned KEY_BYTES = 256,
    parameter int unsigned IV_BYTES  = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    rc4iv_in_if.sink                             i_in,
    rc4iv_out_if.source                          o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_idx,
    input  wire logic [rc4iv_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int unsigned KAW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int unsigned VAW = (IV_BYTES > 1) ? $clog2(IV_BYTES) : 1;

    // configuration
    logic [8:0] r_key_len;
    logic [5:0] r_iv_len;
    logic [8:0] klen;
    logic [8:0] vlen;

    // sequencer state
    rc4iv_pkg::t_state r_state, n_state;
    logic [7:0]     r_i, n_i;
    logic [7:0]     r_j, n_j;
    logic [KAW-1:0] r_kidx, n_kidx;
    logic [VAW-1:0] r_vidx, n_vidx;
    logic [7:0]     r_si, n_si;
    logic [7:0]     r_sj, n_sj;
    logic [7:0]     r_data, n_data;
    logic           r_fwd, n_fwd;
    logic           r_out_vld, n_out_vld;
    logic [7:0]     r_out_byte, n_out_byte;

    // memory hookup
    rc4iv_pkg::t_sbox_req sreq;
    logic [7:0]     sbox_q;
    logic [7:0]     key_q;
    logic [7:0]     iv_q;
    logic           key_we;
    logic           iv_we;
    logic           in_fire;
    rc4iv_pkg::t_op op;

    // schedule mixing terms
    logic [7:0] ks_sadd;
    logic [7:0] ks_key;
    logic [7:0] ks_iv;
    logic [7:0] out_addr;
    logic [7:0] ks_byte;

    // effective lengths clamped to store size
    assign klen = (r_key_len > 9'(KEY_BYTES)) ? 9'(KEY_BYTES) : r_key_len;
    assign vlen = ({3'b000, r_iv_len} > 9'(IV_BYTES)) ? 9'(IV_BYTES)
                                                      : {3'b000, r_iv_len};

    assign op      = rc4iv_pkg::t_op'(i_in.opcode);
    assign in_fire = i_in.valid && i_in.ready;

    rc4iv_sbox u_sbox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sreq),
        .o_rdata (sbox_q)
    );

    rc4iv_ram #(
        .WIDTH (8),
        .DEPTH (KEY_BYTES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (i_in.byte_index[KAW-1:0]),
        .i_wdata (i_in.data_byte),
        .i_raddr (r_kidx),
        .o_rdata (key_q)
    );

    rc4iv_ram #(
        .WIDTH (8),
        .DEPTH (IV_BYTES)
    ) u_iv_ram (
        .i_clk   (i_clk),
        .i_we    (iv_we),
        .i_waddr (i_in.byte_index[VAW-1:0]),
        .i_wdata (i_in.data_byte),
        .i_raddr (r_vidx),
        .o_rdata (iv_q)
    );

    // schedule terms: zero length drops that term (and S[i] with the key)
    assign ks_sadd  = (klen != 9'd0) ? sbox_q : 8'd0;
    assign ks_key   = (klen != 9'd0) ? key_q  : 8'd0;
    assign ks_iv    = (vlen != 9'd0) ? iv_q   : 8'd0;
    assign out_addr = r_si + r_sj;
    assign ks_byte  = r_fwd ? r_si : sbox_q;

    assign o_out.valid    = r_out_vld;
    assign o_out.out_byte = r_out_byte;

    // next state and outputs
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_kidx     = r_kidx;
        n_vidx     = r_vidx;
        n_si       = r_si;
        n_sj       = r_sj;
        n_data     = r_data;
        n_fwd      = r_fwd;
        n_out_vld  = r_out_vld;
        n_out_byte = r_out_byte;
        sreq.rd_addr = r_i;
        sreq.wr_en   = 1'b0;
        sreq.wr_addr = r_i;
        sreq.wr_data = r_sj;
        sreq.clear   = 1'b0;
        i_in.ready   = 1'b0;
        key_we       = 1'b0;
        iv_we        = 1'b0;

        // result taken downstream
        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            rc4iv_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (in_fire) begin
                    unique case (op)
                        rc4iv_pkg::OP_KEY_WR: begin
                            key_we = {1'b0, i_in.byte_index} < 9'(KEY_BYTES);
                        end
                        rc4iv_pkg::OP_IV_WR: begin
                            iv_we = {1'b0, i_in.byte_index} < 9'(IV_BYTES);
                        end
                        rc4iv_pkg::OP_SCHED: begin
                            sreq.clear = 1'b1;
                            n_i        = 8'd0;
                            n_j        = 8'd0;
                            n_kidx     = '0;
                            n_vidx     = '0;
                            n_state    = rc4iv_pkg::ST_KS_RD;
                        end
                        rc4iv_pkg::OP_CRYPT: begin
                            n_i     = r_i + 8'd1;
                            n_data  = i_in.data_byte;
                            n_state = rc4iv_pkg::ST_CR_RI;
                        end
                        default: ;
                    endcase
                end
            end

            // ---- key schedule ----
            rc4iv_pkg::ST_KS_RD: begin
                sreq.rd_addr = r_i;
                n_state      = rc4iv_pkg::ST_KS_J;
            end
            rc4iv_pkg::ST_KS_J: begin
                n_si         = sbox_q;
                n_j          = r_j + ks_sadd + ks_key + ks_iv;
                sreq.rd_addr = n_j;
                // wrap store indexes at the effective lengths
                n_kidx = (({1'b0, 8'(r_kidx)} + 9'd1) == klen) ? '0 : r_kidx + 1'b1;
                n_vidx = (({1'b0, 8'(r_vidx)} + 9'd1) == vlen) ? '0 : r_vidx + 1'b1;
                n_state = rc4iv_pkg::ST_KS_WI;
            end
            rc4iv_pkg::ST_KS_WI: begin
                sreq.wr_en   = 1'b1;
                sreq.wr_addr = r_i;
                sreq.wr_data = sbox_q;
                n_state      = rc4iv_pkg::ST_KS_WJ;
            end
            rc4iv_pkg::ST_KS_WJ: begin
                sreq.wr_en   = 1'b1;
                sreq.wr_addr = r_j;
                sreq.wr_data = r_si;
                n_i          = r_i + 8'd1;
                if (r_i == 8'hFF) begin
                    n_j     = 8'd0;
                    n_state = rc4iv_pkg::ST_IDLE;
                end else begin
                    n_state = rc4iv_pkg::ST_KS_RD;
                end
            end

            // ---- crypt ----
            rc4iv_pkg::ST_CR_RI: begin
                sreq.rd_addr = r_i;
                n_state      = rc4iv_pkg::ST_CR_J;
            end
            rc4iv_pkg::ST_CR_J: begin
                n_si         = sbox_q;
                n_j          = r_j + sbox_q;
                sreq.rd_addr = n_j;
                n_state      = rc4iv_pkg::ST_CR_WI;
            end
            rc4iv_pkg::ST_CR_WI: begin
                n_sj         = sbox_q;
                sreq.wr_en   = 1'b1;
                sreq.wr_addr = r_i;
                sreq.wr_data = sbox_q;
                n_state      = rc4iv_pkg::ST_CR_WJ;
            end
            rc4iv_pkg::ST_CR_WJ: begin
                sreq.wr_en   = 1'b1;
                sreq.wr_addr = r_j;
                sreq.wr_data = r_si;
                sreq.rd_addr = out_addr;
                // output read hits the entry written this cycle: forward
                n_fwd        = (out_addr == r_j);
                n_state      = rc4iv_pkg::ST_CR_OUT;
            end
            rc4iv_pkg::ST_CR_OUT: begin
                // keep the read address so a stalled cycle sees the same word
                sreq.rd_addr = out_addr;
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld  = 1'b1;
                    n_out_byte = r_data ^ ks_byte;
                    n_state    = rc4iv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rc4iv_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rc4iv_pkg::ST_IDLE;
            r_i       <= 8'd0;
            r_j       <= 8'd0;
            r_out_vld <= 1'b0;
            r_key_len <= 9'd0;
            r_iv_len  <= 6'd0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_j       <= n_j;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                if (i_cfg_idx == rc4iv_pkg::CFG_KEY_LEN) begin
                    r_key_len <= i_cfg_data;
                end else if (i_cfg_idx == rc4iv_pkg::CFG_IV_LEN) begin
                    r_iv_len <= i_cfg_data[5:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kidx     <= n_kidx;
        r_vidx     <= n_vidx;
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_data     <= n_data;
        r_fwd      <= n_fwd;
        r_out_byte <= n_out_byte;
    end

    // ---- assertions ----
    // a new result only comes out of the crypt output step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == rc4iv_pkg::ST_CR_OUT)
        else $error("result loaded outside crypt output step");

    // schedule ends after the last entry with j back at zero
    a_ks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc4iv_pkg::ST_KS_WJ && r_i == 8'hFF)
        |=> (r_state == rc4iv_pkg::ST_IDLE && r_j == 8'd0 && r_i == 8'd0))
        else $error("key schedule did not finish cleanly");

    // S-box is written only in swap steps
    a_swap_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sreq.wr_en |-> (r_state == rc4iv_pkg::ST_KS_WI || r_state == rc4iv_pkg::ST_KS_WJ
                     || r_state == rc4iv_pkg::ST_CR_WI || r_state == rc4iv_pkg::ST_CR_WJ))
        else $error("S-box write outside swap step");

endmodule
`default_nettype wire

>>> src/rc4iv_ram.sv
`default_nettype none
// ============================================================================
// rc4iv_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module rc4iv_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> src/rc4iv_sbox.sv
`default_nettype none
// ============================================================================
// rc4iv_sbox
// 256-entry S-box store. An entry without its valid bit reads as its own
// address, so reset and the schedule's identity fill need no clearing pass.
// ============================================================================
module rc4iv_sbox (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rc4iv_pkg::t_sbox_req  i_req,
    output logic [7:0]                 o_rdata
);
    logic [rc4iv_pkg::SBOX_DEPTH-1:0] r_vld;
    logic                             r_rd_vld;
    logic [rc4iv_pkg::SBOX_AW-1:0]    r_rd_addr;
    logic [7:0]                       ram_q;

    rc4iv_ram #(
        .WIDTH (8),
        .DEPTH (rc4iv_pkg::SBOX_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_waddr (i_req.wr_addr),
        .i_wdata (i_req.wr_data),
        .i_raddr (i_req.rd_addr),
        .o_rdata (ram_q)
    );

    // valid bits: cleared as a group, set per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.clear) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    // track read address and validity alongside the RAM read register
    always_ff @(posedge i_clk) begin
        r_rd_addr <= i_req.rd_addr;
        r_rd_vld  <= r_vld[i_req.rd_addr];
    end

    assign o_rdata = r_rd_vld ? ram_q : r_rd_addr;
endmodule
`default_nettype wire
